>>> hdl/sgc_pkg.sv
// sgc_pkg: types and constants shared by the swing gate controller.
// Gate and learning state codes, drive codes, register indexes and reset values.
// No dependencies.
package sgc_pkg;

	localparam int POS_WIDTH = 16;
	localparam int CNT_W     = 16;
	localparam int CMP_W     = ((POS_WIDTH > CNT_W) ? POS_WIDTH : CNT_W) + 2;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam logic [15:0] CURRENT_LIMIT_RST = 16'd1000;
	localparam logic [15:0] FULL_TRAVEL_RST   = 16'd20;
	localparam logic [7:0]  OBST_MARGIN_RST   = 8'd3;
	localparam logic [15:0] RUN_TIMEOUT_RST   = 16'd30;

	typedef enum logic [3:0] {
		ST_INIT    = 4'd0,
		ST_IDLE    = 4'd1,
		ST_CAL     = 4'd2,
		ST_OC      = 4'd3,
		ST_BOUND   = 4'd4,
		ST_STOP    = 4'd5,
		ST_OBST    = 4'd6,
		ST_REV     = 4'd7,
		ST_TIMEOUT = 4'd8,
		ST_KEY     = 4'd9
	} gate_state_t;

	typedef enum logic [3:0] {
		LS_START         = 4'd0,
		LS_WAIT_OPEN     = 4'd1,
		LS_M1_CLOSE      = 4'd2,
		LS_M2_CLOSE      = 4'd3,
		LS_M2_OPEN_MEAS  = 4'd4,
		LS_M1_OPEN_MEAS  = 4'd5,
		LS_M1_CLOSE_MEAS = 4'd6,
		LS_M2_CLOSE_MEAS = 4'd7,
		LS_STORE         = 4'd8,
		LS_END           = 4'd9
	} learn_step_t;

	typedef enum logic [1:0] {
		DRV_STOP  = 2'd0,
		DRV_OPEN  = 2'd1,
		DRV_CLOSE = 2'd2
	} drive_t;

	typedef enum logic [1:0] {
		REG_CURRENT_LIMIT = 2'd0,
		REG_FULL_TRAVEL   = 2'd1,
		REG_OBST_MARGIN   = 2'd2,
		REG_RUN_TIMEOUT   = 2'd3
	} cfg_reg_t;

endpackage

>>> hdl/swing_gate_controller_top.sv
// swing_gate_controller_top: per-tick two-motor swing gate controller.
// Input word register, one pass of state logic, result word register; APB registers.
// Depends on sgc_pkg.
//
// channel  dir  handshake               contents
// s_*      in   s_tvalid / s_tready     one tick of buttons, IR and motor currents
// m_*      out  m_tvalid / m_tready     drives, lamp, state, direction, positions
// apb      in   psel/penable/pready     four config registers at 0x0, 0x4, 0x8, 0xC
//
// One word per cycle sustained while the output is not stalled; a result passes through
// the input register, then the result register. The gate state updates as a word moves
// from the input register into the result register. A stalled output holds both
// stages; s_tready drops only when both are full. Reset restores all state and
// register defaults at once.
module swing_gate_controller_top
	import sgc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// rf_signal[0], oc_button[1], learn_button[2], key_button[3], ir_obstacle[4],
	// current_m1[20:5], current_m2[36:21], zero[39:37]
	input  logic [39:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// m1_drive[1:0], m2_drive[3:2], lamp[4], gate_state_out[8:5], closing[9],
	// m1_position[25:10], m2_position[41:26], calibration_done[42], zero[47:43]
	output logic [47:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// config registers
	logic [15:0] current_limit_q, full_travel_q, run_timeout_q;
	logic [7:0]  obst_margin_q;
	cfg_reg_t    cfg_idx;
	logic        cfg_we;

	// input stage
	logic        valid_s1, cmd_s1, learn_s1, key_s1, ir_s1;
	logic [15:0] cur1_s1, cur2_s1;

	// result stage
	logic                 valid_s2, lamp_s2, closing_s2, cal_s2;
	drive_t               m1_drv_s2, m2_drv_s2;
	gate_state_t          state_s2;
	logic [15:0]          m1_pos_s2, m2_pos_s2;

	// gate state
	gate_state_t          gate_state_q, gs_d;
	learn_step_t          learn_step_q, ls_d;
	drive_t               m1_cmd_q, m2_cmd_q, m1_d, m2_d;
	logic                 lamp_q, lamp_d, close_next_q, cn_d;
	logic [POS_WIDTH-1:0] m1_pos_q, m2_pos_q, m1_pos_d, m2_pos_d;
	logic [CNT_W-1:0]     travel_q, travel_d, tt_w;

	logic adv, oc1, oc2;

	function automatic logic near_obst(input logic [POS_WIDTH-1:0] pos, input logic cn,
			input logic [15:0] ftt, input logic [7:0] mg);
		logic signed [CMP_W-1:0] p, lim;
		p   = signed'(CMP_W'(pos));
		lim = signed'(CMP_W'(ftt)) - signed'(CMP_W'(mg));
		if (cn)
			return CMP_W'(pos) > CMP_W'(mg);
		return p < lim;
	endfunction

	function automatic logic [POS_WIDTH-1:0] move_pos(input logic [POS_WIDTH-1:0] pos,
			input drive_t drv);
		logic [POS_WIDTH-1:0] r;
		r = pos;
		if (drv == DRV_OPEN && pos != '1)
			r = pos + 1'b1;
		else if (drv == DRV_CLOSE && pos != '0)
			r = pos - 1'b1;
		return r;
	endfunction

	// APB
	assign pready  = 1'b1;
	assign cfg_idx = cfg_reg_t'(paddr[3:2]);
	assign cfg_we  = psel & penable & pwrite & pready;

	always_comb begin
		unique case (cfg_idx)
			REG_CURRENT_LIMIT: prdata = {16'b0, current_limit_q};
			REG_FULL_TRAVEL:   prdata = {16'b0, full_travel_q};
			REG_OBST_MARGIN:   prdata = {24'b0, obst_margin_q};
			REG_RUN_TIMEOUT:   prdata = {16'b0, run_timeout_q};
			default:           prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_limit_q <= CURRENT_LIMIT_RST;
			full_travel_q   <= FULL_TRAVEL_RST;
			obst_margin_q   <= OBST_MARGIN_RST;
			run_timeout_q   <= RUN_TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_CURRENT_LIMIT: current_limit_q <= pwdata[15:0];
				REG_FULL_TRAVEL:   full_travel_q   <= pwdata[15:0];
				REG_OBST_MARGIN:   obst_margin_q   <= pwdata[7:0];
				REG_RUN_TIMEOUT:   run_timeout_q   <= pwdata[15:0];
				default:           current_limit_q <= current_limit_q;
			endcase
		end
	end

	// handshake
	assign adv      = ~valid_s2 | m_tready;
	assign s_tready = ~valid_s1 | adv;
	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'b0, cal_s2, m2_pos_s2, m1_pos_s2, closing_s2, state_s2,
		lamp_s2, m2_drv_s2, m1_drv_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1   <= s_tdata[0] | s_tdata[1];
			learn_s1 <= s_tdata[2];
			key_s1   <= s_tdata[3];
			ir_s1    <= s_tdata[4];
			cur1_s1  <= s_tdata[20:5];
			cur2_s1  <= s_tdata[36:21];
		end
	end

	assign oc1 = cur1_s1 > current_limit_q;
	assign oc2 = cur2_s1 > current_limit_q;

	// one tick of the gate state machine
	always_comb begin
		gs_d   = gate_state_q;
		ls_d   = learn_step_q;
		m1_d   = m1_cmd_q;
		m2_d   = m2_cmd_q;
		lamp_d = lamp_q;
		cn_d   = close_next_q;
		tt_w   = travel_q;
		unique case (gate_state_q) inside
			ST_INIT: begin
				m1_d   = DRV_STOP;
				m2_d   = DRV_STOP;
				lamp_d = 1'b0;
				cn_d   = 1'b1;
				gs_d   = ST_IDLE;
			end
			ST_IDLE: begin
				lamp_d = 1'b0;
				if (key_s1)
					gs_d = ST_KEY;
				else if (ir_s1)
					gs_d = ST_IDLE;
				else if (learn_s1)
					gs_d = ST_CAL;
				else if (cmd_s1)
					gs_d = ST_OC;
			end
			ST_CAL: begin
				unique case (learn_step_q) inside
					LS_START: begin
						m1_d = DRV_OPEN;
						m2_d = DRV_OPEN;
						ls_d = LS_WAIT_OPEN;
					end
					LS_WAIT_OPEN: begin
						if (oc1)
							m1_d = DRV_STOP;
						if (oc2)
							m2_d = DRV_STOP;
						if (m1_d == DRV_STOP && m2_d == DRV_STOP)
							ls_d = LS_M1_CLOSE;
					end
					LS_M1_CLOSE, LS_M1_CLOSE_MEAS: begin
						m1_d = DRV_CLOSE;
						if (oc1) begin
							m1_d = DRV_STOP;
							ls_d = (learn_step_q == LS_M1_CLOSE) ? LS_M2_CLOSE
								: LS_M2_CLOSE_MEAS;
						end
					end
					LS_M2_CLOSE, LS_M2_CLOSE_MEAS: begin
						m2_d = DRV_CLOSE;
						if (oc2) begin
							m2_d = DRV_STOP;
							ls_d = (learn_step_q == LS_M2_CLOSE) ? LS_M2_OPEN_MEAS
								: LS_STORE;
						end
					end
					LS_M2_OPEN_MEAS: begin
						m2_d = DRV_OPEN;
						if (oc2) begin
							m2_d = DRV_STOP;
							ls_d = LS_M1_OPEN_MEAS;
						end
					end
					LS_M1_OPEN_MEAS: begin
						m1_d = DRV_OPEN;
						if (oc1) begin
							m1_d = DRV_STOP;
							ls_d = LS_M1_CLOSE_MEAS;
						end
					end
					LS_STORE: ls_d = LS_END;
					LS_END:   gs_d = ST_IDLE;
					default:  ls_d = learn_step_q;
				endcase
				if (cmd_s1) begin
					m1_d = DRV_STOP;
					m2_d = DRV_STOP;
					gs_d = ST_STOP;
				end
			end
			ST_OC, ST_BOUND: begin
				if (gate_state_q == ST_OC) begin
					tt_w = '0;
					if (close_next_q)
						m1_d = DRV_CLOSE;
					else
						m2_d = DRV_OPEN;
					gs_d = ST_BOUND;
				end
				lamp_d = ~lamp_q;
				if (close_next_q) begin
					if (m2_pos_q > m1_pos_q)
						m2_d = DRV_CLOSE;
				end else if (m1_pos_q < m2_pos_q) begin
					m1_d = DRV_OPEN;
				end
				if (tt_w >= run_timeout_q)
					gs_d = ST_TIMEOUT;
				if (oc1) begin
					m1_d = DRV_STOP;
					if (near_obst(m1_pos_q, close_next_q, full_travel_q, obst_margin_q))
						gs_d = ST_OBST;
				end
				if (oc2) begin
					m2_d = DRV_STOP;
					if (near_obst(m2_pos_q, close_next_q, full_travel_q, obst_margin_q))
						gs_d = ST_OBST;
				end
				if (m1_d == DRV_STOP && m2_d == DRV_STOP)
					gs_d = ST_STOP;
				if (cmd_s1) begin
					m1_d = DRV_STOP;
					m2_d = DRV_STOP;
					gs_d = ST_STOP;
				end
			end
			ST_OBST: begin
				lamp_d = ~lamp_q;
				m1_d   = DRV_STOP;
				m2_d   = DRV_STOP;
				if (close_next_q)
					gs_d = ST_REV;
				if (cmd_s1)
					gs_d = ST_STOP;
			end
			ST_REV: begin
				lamp_d = ~lamp_q;
				m1_d   = DRV_STOP;
				m2_d   = DRV_STOP;
				cn_d   = 1'b0;
				gs_d   = ST_OC;
			end
			ST_STOP: begin
				cn_d   = ~close_next_q;
				lamp_d = 1'b0;
				m1_d   = DRV_STOP;
				m2_d   = DRV_STOP;
				gs_d   = ST_IDLE;
			end
			ST_TIMEOUT: begin
				lamp_d = ~lamp_q;
				m1_d   = DRV_STOP;
				m2_d   = DRV_STOP;
				if (cmd_s1)
					gs_d = ST_STOP;
			end
			ST_KEY:  gs_d = ST_IDLE;
			default: gs_d = ST_INIT;
		endcase
		travel_d = (tt_w != CNT_MAX) ? tt_w + 1'b1 : tt_w;
		m1_pos_d = move_pos(m1_pos_q, m1_d);
		m2_pos_d = move_pos(m2_pos_q, m2_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_state_q <= ST_INIT;
			learn_step_q <= LS_START;
			m1_cmd_q     <= DRV_STOP;
			m2_cmd_q     <= DRV_STOP;
			lamp_q       <= 1'b0;
			close_next_q <= 1'b1;
			m1_pos_q     <= '0;
			m2_pos_q     <= '0;
			travel_q     <= '0;
			valid_s2     <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				gate_state_q <= gs_d;
				learn_step_q <= ls_d;
				m1_cmd_q     <= m1_d;
				m2_cmd_q     <= m2_d;
				lamp_q       <= lamp_d;
				close_next_q <= cn_d;
				m1_pos_q     <= m1_pos_d;
				m2_pos_q     <= m2_pos_d;
				travel_q     <= travel_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			m1_drv_s2  <= m1_d;
			m2_drv_s2  <= m2_d;
			lamp_s2    <= lamp_d;
			state_s2   <= gs_d;
			closing_s2 <= cn_d;
			m1_pos_s2  <= 16'(m1_pos_d);
			m2_pos_s2  <= 16'(m2_pos_d);
			cal_s2     <= (ls_d == LS_END);
		end
	end

	// an empty result stage never blocks the input side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> s_tready)
		else $error("s_tready low with empty result stage");

	// a word reporting STOP always carries stopped motors
	a_stop_drives: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && state_s2 == ST_STOP) |-> (m1_drv_s2 == DRV_STOP && m2_drv_s2 == DRV_STOP))
		else $error("STOP state with a motor driven");

	// learning never leaves its end step
	a_learn_end_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		learn_step_q == LS_END |=> learn_step_q == LS_END)
		else $error("learning step left its end step");

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for swing_gate_controller_top over its stream and APB ports.
// Every accepted tick word runs through an in-bench gate model; result words are checked per field.
// Depends on sgc_pkg and the RTL top only.
module tb;
	import sgc_pkg::*;

	localparam int LIMIT_CYCLES = 20000;
	localparam int HOLD_CYCLES  = 200;
	localparam int MAX_PRINTS   = 40;

	localparam int PROF_RUN   = 0;
	localparam int PROF_LEARN = 1;
	localparam int PROF_NOISE = 2;

	// rf, oc_btn, learn, key, ir, cur_m1, cur_m2 from the lowest bit up
	typedef struct packed {
		logic [15:0] cur_m2;
		logic [15:0] cur_m1;
		logic        ir;
		logic        key;
		logic        learn;
		logic        oc_btn;
		logic        rf;
	} gate_tick_t;

	// m1_drv, m2_drv, lamp, state, closing, m1_pos, m2_pos, cal_done from the lowest bit up
	typedef struct packed {
		logic        cal_done;
		logic [15:0] m2_pos;
		logic [15:0] m1_pos;
		logic        closing;
		logic [3:0]  state;
		logic        lamp;
		logic [1:0]  m2_drv;
		logic [1:0]  m1_drv;
	} gate_result_t;

	typedef struct {
		gate_tick_t   tick;
		bit           typed;
		gate_result_t want;
	} dir_row_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	swing_gate_controller_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// gate model state and register copies
	gate_state_t g_state;
	learn_step_t g_step;
	drive_t      g_m1, g_m2;
	logic        g_lamp, g_close;
	logic [15:0] g_pos1, g_pos2, g_travel;
	logic [15:0] g_lim, g_ftt, g_tmo;
	logic [7:0]  g_margin;

	gate_result_t pending_results[$];
	dir_row_t     dir_rows[$];

	int  src_idle_pct = 0;
	int  snk_stall_pct = 0;
	bit  hold_req = 1'b0;
	int  mismatch_count = 0;
	int  checked_count = 0;
	int  sent_count = 0;
	int  reg_writes = 0;
	int  cycles = 0;
	gate_result_t got_res, want_res;

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTS)
			$display("mismatch at result word %0d: %s", checked_count, msg);
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	function automatic void gate_model_reset();
		g_state  = ST_INIT;
		g_step   = LS_START;
		g_m1     = DRV_STOP;
		g_m2     = DRV_STOP;
		g_lamp   = 1'b0;
		g_close  = 1'b1;
		g_pos1   = '0;
		g_pos2   = '0;
		g_travel = '0;
		g_lim    = CURRENT_LIMIT_RST;
		g_ftt    = FULL_TRAVEL_RST;
		g_margin = OBST_MARGIN_RST;
		g_tmo    = RUN_TIMEOUT_RST;
	endfunction

	function automatic bit learn_advance(input bit oc1, input bit oc2);
		bit done;
		done = 1'b0;
		case (g_step)
			LS_START: begin
				g_m1 = DRV_OPEN;
				g_m2 = DRV_OPEN;
				g_step = LS_WAIT_OPEN;
			end
			LS_WAIT_OPEN: begin
				if (oc1) g_m1 = DRV_STOP;
				if (oc2) g_m2 = DRV_STOP;
				if (g_m1 == DRV_STOP && g_m2 == DRV_STOP) g_step = LS_M1_CLOSE;
			end
			LS_M1_CLOSE: begin
				g_m1 = DRV_CLOSE;
				if (oc1) begin
					g_m1 = DRV_STOP;
					g_step = LS_M2_CLOSE;
				end
			end
			LS_M2_CLOSE: begin
				g_m2 = DRV_CLOSE;
				if (oc2) begin
					g_m2 = DRV_STOP;
					g_step = LS_M2_OPEN_MEAS;
				end
			end
			LS_M2_OPEN_MEAS: begin
				g_m2 = DRV_OPEN;
				if (oc2) begin
					g_m2 = DRV_STOP;
					g_step = LS_M1_OPEN_MEAS;
				end
			end
			LS_M1_OPEN_MEAS: begin
				g_m1 = DRV_OPEN;
				if (oc1) begin
					g_m1 = DRV_STOP;
					g_step = LS_M1_CLOSE_MEAS;
				end
			end
			LS_M1_CLOSE_MEAS: begin
				g_m1 = DRV_CLOSE;
				if (oc1) begin
					g_m1 = DRV_STOP;
					g_step = LS_M2_CLOSE_MEAS;
				end
			end
			LS_M2_CLOSE_MEAS: begin
				g_m2 = DRV_CLOSE;
				if (oc2) begin
					g_m2 = DRV_STOP;
					g_step = LS_STORE;
				end
			end
			LS_STORE: g_step = LS_END;
			LS_END: done = 1'b1;
			default: ;
		endcase
		return done;
	endfunction

	// overcurrent away from the end stop counts as an obstacle; open side is signed
	function automatic bit in_obstacle_zone(input logic [15:0] pos);
		if (g_close)
			return pos > {8'd0, g_margin};
		return int'(pos) < int'(g_ftt) - int'(g_margin);
	endfunction

	function automatic gate_state_t travel_check(input bit oc1, input bit oc2, input bit cmd,
			input gate_state_t nxt);
		g_lamp = ~g_lamp;
		if (g_close) begin
			if (g_pos2 > g_pos1) g_m2 = DRV_CLOSE;
		end else begin
			if (g_pos1 < g_pos2) g_m1 = DRV_OPEN;
		end
		if (g_travel >= g_tmo) nxt = ST_TIMEOUT;
		if (oc1) begin
			g_m1 = DRV_STOP;
			if (in_obstacle_zone(g_pos1)) nxt = ST_OBST;
		end
		if (oc2) begin
			g_m2 = DRV_STOP;
			if (in_obstacle_zone(g_pos2)) nxt = ST_OBST;
		end
		if (g_m1 == DRV_STOP && g_m2 == DRV_STOP) nxt = ST_STOP;
		if (cmd) begin
			g_m1 = DRV_STOP;
			g_m2 = DRV_STOP;
			nxt = ST_STOP;
		end
		return nxt;
	endfunction

	function automatic logic [15:0] move_pos(input logic [15:0] p, input drive_t c);
		if (c == DRV_OPEN && p != 16'hFFFF) return p + 16'd1;
		if (c == DRV_CLOSE && p != 16'd0) return p - 16'd1;
		return p;
	endfunction

	function automatic void stop_motors();
		g_m1 = DRV_STOP;
		g_m2 = DRV_STOP;
	endfunction

	function automatic gate_result_t gate_model_step(input gate_tick_t t);
		bit cmd, oc1, oc2;
		gate_state_t nxt;
		gate_result_t r;
		cmd = t.rf | t.oc_btn;
		oc1 = t.cur_m1 > g_lim;
		oc2 = t.cur_m2 > g_lim;
		nxt = g_state;
		case (g_state)
			ST_INIT: begin
				stop_motors();
				g_lamp = 1'b0;
				g_close = 1'b1;
				nxt = ST_IDLE;
			end
			ST_IDLE: begin
				nxt = ST_IDLE;
				g_lamp = 1'b0;
				if (cmd) nxt = ST_OC;
				if (t.learn) nxt = ST_CAL;
				if (t.ir) nxt = ST_IDLE;
				if (t.key) nxt = ST_KEY;
			end
			ST_CAL: begin
				if (learn_advance(oc1, oc2)) nxt = ST_IDLE;
				if (cmd) begin
					stop_motors();
					nxt = ST_STOP;
				end
			end
			ST_OC: begin
				g_travel = '0;
				if (g_close) g_m1 = DRV_CLOSE;
				else g_m2 = DRV_OPEN;
				nxt = travel_check(oc1, oc2, cmd, ST_BOUND);
			end
			ST_BOUND: nxt = travel_check(oc1, oc2, cmd, nxt);
			ST_OBST: begin
				g_lamp = ~g_lamp;
				stop_motors();
				if (g_close) nxt = ST_REV;
				if (cmd) nxt = ST_STOP;
			end
			ST_REV: begin
				g_lamp = ~g_lamp;
				stop_motors();
				g_close = 1'b0;
				nxt = ST_OC;
			end
			ST_STOP: begin
				g_close = ~g_close;
				g_lamp = 1'b0;
				stop_motors();
				nxt = ST_IDLE;
			end
			ST_TIMEOUT: begin
				g_lamp = ~g_lamp;
				stop_motors();
				if (cmd) nxt = ST_STOP;
			end
			ST_KEY: nxt = ST_IDLE;
			default: nxt = ST_INIT;
		endcase
		g_state = nxt;
		if (g_travel != 16'hFFFF) g_travel = g_travel + 16'd1;
		g_pos1 = move_pos(g_pos1, g_m1);
		g_pos2 = move_pos(g_pos2, g_m2);
		r.m1_drv   = g_m1;
		r.m2_drv   = g_m2;
		r.lamp     = g_lamp;
		r.state    = g_state;
		r.closing  = g_close;
		r.m1_pos   = g_pos1;
		r.m2_pos   = g_pos2;
		r.cal_done = (g_step == LS_END);
		return r;
	endfunction

	// called at a falling edge; leaves tvalid high after acceptance
	task automatic send_tick(input gate_tick_t t, input bit typed, input gate_result_t want);
		gate_result_t pred;
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, t};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pred = gate_model_step(t);
		pending_results.push_back(typed ? want : pred);
		sent_count++;
		@(negedge clk);
	endtask

	task automatic apb_xfer(input bit wr, input logic [3:0] addr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [15:0] value);
		logic [31:0] rd;
		logic [15:0] kept;
		kept = (idx == REG_OBST_MARGIN) ? {8'd0, value[7:0]} : value;
		apb_xfer(1'b1, {idx, 2'b00}, {16'd0, value}, rd);
		case (idx)
			REG_CURRENT_LIMIT: g_lim = kept;
			REG_FULL_TRAVEL:   g_ftt = kept;
			REG_OBST_MARGIN:   g_margin = kept[7:0];
			REG_RUN_TIMEOUT:   g_tmo = kept;
			default: ;
		endcase
		apb_xfer(1'b0, {idx, 2'b00}, 32'd0, rd);
		if (rd !== {16'd0, kept})
			report_mismatch($sformatf("register %0d read %0h want %0h", idx, rd, kept));
		reg_writes++;
	endtask

	// called at a falling edge right after the last send
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_config(input logic [15:0] lim, input logic [15:0] ftt,
			input logic [7:0] margin, input logic [15:0] tmo);
		drain();
		write_reg(REG_CURRENT_LIMIT, lim);
		write_reg(REG_FULL_TRAVEL, ftt);
		write_reg(REG_OBST_MARGIN, {8'd0, margin});
		write_reg(REG_RUN_TIMEOUT, tmo);
	endtask

	function automatic gate_tick_t tk(input bit rf, input bit oc, input bit lr, input bit ky,
			input bit ir, input logic [15:0] c1, input logic [15:0] c2);
		gate_tick_t t;
		t = '{cur_m2: c2, cur_m1: c1, ir: ir, key: ky, learn: lr, oc_btn: oc, rf: rf};
		return t;
	endfunction

	function automatic gate_result_t rs(input drive_t m1, input drive_t m2, input bit lamp,
			input gate_state_t st, input bit closing, input logic [15:0] p1,
			input logic [15:0] p2, input bit cal);
		gate_result_t r;
		r = '{cal_done: cal, m2_pos: p2, m1_pos: p1, closing: closing, state: st,
			lamp: lamp, m2_drv: m2, m1_drv: m1};
		return r;
	endfunction

	function automatic logic [15:0] rand_current(input int trip_pct);
		if ($urandom_range(99) < trip_pct) begin
			if (g_lim == 16'hFFFF) return 16'($urandom_range(16'hFFFF));
			return 16'($urandom_range(16'hFFFF, int'(g_lim) + 1));
		end
		if ($urandom_range(99) < 5) return 16'($urandom_range(16'hFFFF));
		return 16'($urandom_range(int'(g_lim), 0));
	endfunction

	function automatic gate_tick_t rand_tick(input int prof);
		gate_tick_t t;
		int cmd_pct, learn_pct, key_pct, ir_pct, trip_pct;
		case (prof)
			PROF_RUN:   begin cmd_pct = 5;  learn_pct = 3;  key_pct = 3;  ir_pct = 10; trip_pct = 6;  end
			PROF_LEARN: begin cmd_pct = 1;  learn_pct = 15; key_pct = 2;  ir_pct = 5;  trip_pct = 20; end
			default:    begin cmd_pct = 30; learn_pct = 30; key_pct = 30; ir_pct = 40; trip_pct = 35; end
		endcase
		t = '0;
		if ($urandom_range(99) < cmd_pct) begin
			case ($urandom_range(2))
				0: t.rf = 1'b1;
				1: t.oc_btn = 1'b1;
				default: begin
					t.rf = 1'b1;
					t.oc_btn = 1'b1;
				end
			endcase
		end
		t.learn  = $urandom_range(99) < learn_pct;
		t.key    = $urandom_range(99) < key_pct;
		t.ir     = $urandom_range(99) < ir_pct;
		t.cur_m1 = rand_current(trip_pct);
		t.cur_m2 = rand_current(trip_pct);
		return t;
	endfunction

	// stretches of one traffic profile each
	task automatic run_random(input int n_items);
		int sent, seg, k, prof;
		sent = 0;
		while (sent < n_items) begin
			k = $urandom_range(99);
			prof = (k < 60) ? PROF_RUN : (k < 85) ? PROF_LEARN : PROF_NOISE;
			seg = $urandom_range(50, 10);
			repeat (seg) begin
				send_tick(rand_tick(prof), 1'b0, '0);
				sent++;
			end
		end
	endtask

	// open the gate without current trips until an opening run times out
	task automatic run_open_to_timeout();
		gate_tick_t t;
		for (int n = 0; n < 400; n++) begin
			if (g_state == ST_TIMEOUT && !g_close) break;
			t = '0;
			case (g_state)
				ST_IDLE, ST_TIMEOUT, ST_OBST, ST_CAL: t.rf = 1'b1;
				ST_BOUND: if (g_close) t.oc_btn = 1'b1;
				default: ;
			endcase
			send_tick(t, 1'b0, '0);
		end
	endtask

	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			m_tready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_res = m_tdata[42:0];
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result word %0h with nothing pending", m_tdata));
			end else begin
				want_res = pending_results.pop_front();
				check_field("m1_drive", got_res.m1_drv, want_res.m1_drv);
				check_field("m2_drive", got_res.m2_drv, want_res.m2_drv);
				check_field("lamp", got_res.lamp, want_res.lamp);
				check_field("gate_state", got_res.state, want_res.state);
				check_field("closing", got_res.closing, want_res.closing);
				check_field("m1_position", got_res.m1_pos, want_res.m1_pos);
				check_field("m2_position", got_res.m2_pos, want_res.m2_pos);
				check_field("calibration_done", got_res.cal_done, want_res.cal_done);
			end
			checked_count++;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d words pending", cycles, pending_results.size());
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		gate_model_reset();
		// after reset through key store, a stopped run and the ir override
		dir_rows.push_back('{tk(0,0,0,0,0,0,0), 1,
			rs(DRV_STOP, DRV_STOP, 0, ST_IDLE, 1, 0, 0, 0)});
		dir_rows.push_back('{tk(0,0,0,1,0,0,0), 1,
			rs(DRV_STOP, DRV_STOP, 0, ST_KEY, 1, 0, 0, 0)});
		dir_rows.push_back('{tk(0,0,0,0,0,0,0), 1,
			rs(DRV_STOP, DRV_STOP, 0, ST_IDLE, 1, 0, 0, 0)});
		dir_rows.push_back('{tk(1,1,0,0,1,0,0), 1,
			rs(DRV_STOP, DRV_STOP, 0, ST_IDLE, 1, 0, 0, 0)});
		dir_rows.push_back('{tk(1,0,0,0,0,0,0), 1,
			rs(DRV_STOP, DRV_STOP, 0, ST_OC, 1, 0, 0, 0)});
		dir_rows.push_back('{tk(0,0,0,0,0,0,0), 1,
			rs(DRV_CLOSE, DRV_STOP, 1, ST_BOUND, 1, 0, 0, 0)});
		dir_rows.push_back('{tk(0,1,0,0,0,0,0), 1,
			rs(DRV_STOP, DRV_STOP, 0, ST_STOP, 1, 0, 0, 0)});
		dir_rows.push_back('{tk(0,0,0,0,0,0,0), 1,
			rs(DRV_STOP, DRV_STOP, 0, ST_IDLE, 0, 0, 0, 0)});
		// open, obstacle on the open side, then close with currents at and over the limit
		dir_rows.push_back('{tk(0,1,0,0,0,0,0), 0, '0});
		dir_rows.push_back('{tk(0,0,0,0,0,0,0), 0, '0});
		dir_rows.push_back('{tk(0,0,0,0,0,0,0), 0, '0});
		dir_rows.push_back('{tk(0,0,0,0,0,16'hFFFF,0), 0, '0});
		dir_rows.push_back('{tk(0,0,0,0,0,0,0), 0, '0});
		dir_rows.push_back('{tk(1,0,0,0,0,0,0), 0, '0});
		dir_rows.push_back('{tk(0,0,0,0,0,0,0), 0, '0});
		dir_rows.push_back('{tk(1,0,0,0,0,0,0), 0, '0});
		dir_rows.push_back('{tk(0,0,0,0,0,1000,1000), 0, '0});
		dir_rows.push_back('{tk(0,0,0,0,0,0,1001), 0, '0});
		dir_rows.push_back('{tk(0,0,0,0,0,1001,16'hFFFF), 0, '0});
		dir_rows.push_back('{tk(1,0,0,0,0,0,0), 0, '0});
		dir_rows.push_back('{tk(0,0,0,0,0,0,0), 0, '0});
		// learning entry, ir override, first steps of the sequence
		dir_rows.push_back('{tk(0,0,1,0,1,0,0), 0, '0});
		dir_rows.push_back('{tk(0,0,1,0,0,0,0), 0, '0});
		dir_rows.push_back('{tk(0,0,0,0,0,0,0), 0, '0});
		dir_rows.push_back('{tk(0,0,0,0,0,16'hFFFF,16'hFFFF), 0, '0});

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_tick(dir_rows[i].tick, dir_rows[i].typed, dir_rows[i].want);

		// margin above travel time: open-side check never trips
		set_config(16'd500, 16'd0, 8'd255, 16'd40);
		run_random(200);

		src_idle_pct = 67;
		set_config(16'd2000, 16'hFFFF, 8'd0, 16'd0);
		run_random(200);

		src_idle_pct = 0;
		set_config(16'hFFFF, 16'd100, 8'd10, 16'd100);
		run_open_to_timeout();

		snk_stall_pct = 67;
		set_config(16'd0, 16'd50, 8'd5, 16'd100);
		run_random(200);

		src_idle_pct = 22;
		snk_stall_pct = 22;
		set_config(CURRENT_LIMIT_RST, FULL_TRAVEL_RST, OBST_MARGIN_RST, RUN_TIMEOUT_RST);
		hold_req = 1'b1;
		run_random(250);

		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("run: %0d tick words sent, %0d result words checked, %0d register writes",
			sent_count, checked_count, reg_writes);
		$display("run: learning %s, %0d mismatches",
			(g_step == LS_END) ? "completed" : "not completed", mismatch_count);
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
